// ===== rtl/core/lbrgb_pkg.sv =====
package lbrgb_pkg;

  localparam int LABEL_W = 16;
  localparam int LEVEL_W = 8;
  localparam int LAB_W   = 7;

  localparam int HUE_STEP    = 35;
  localparam int HUE_RANGE   = 360;
  localparam int SECTOR_SPAN = 60;
  localparam int SAT_SCALE   = 100;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
  localparam logic [LEVEL_W-1:0] GRAY_LEVEL = 8'd128;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic             zero;
    logic             big;
    logic [LAB_W-1:0] lab;
    sector_t          sector;
    logic [5:0]       rem;
  } hue_item_t;

  typedef struct packed {
    logic               zero;
    logic               big;
    sector_t            sector;
    logic [LEVEL_W-1:0] p;
    logic [LEVEL_W-1:0] q;
    logic [LEVEL_W-1:0] t;
  } level_item_t;

endpackage

// ===== rtl/core/lbrgb_in_if.sv =====
interface lbrgb_in_if;
  import lbrgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;

  modport source (output valid, output label, input ready);
  modport sink (input valid, input label, output ready);
endinterface

// ===== rtl/core/lbrgb_out_if.sv =====
interface lbrgb_out_if;
  import lbrgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/lbrgb_hue.sv =====
module lbrgb_hue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [lbrgb_pkg::LABEL_W-1:0] label,
  output logic                          out_valid,
  output lbrgb_pkg::hue_item_t          item
);
  import lbrgb_pkg::*;

  typedef struct packed {
    logic             zero;
    logic             big;
    logic [LAB_W-1:0] lab;
  } tag_t;

  logic [4:0]  vld;
  tag_t        tag [5];

  logic [12:0] x1;
  logic [12:0] x2;
  logic [3:0]  qd2;
  logic [8:0]  hue3;
  logic [8:0]  hue4;
  logic [2:0]  s4;
  sector_t     sector5;
  logic [5:0]  rem5;

  logic [12:0] x_next;
  logic [3:0]  qd_next;
  logic [12:0] hue_diff;
  logic [8:0]  hue_next;
  logic [2:0]  s_next;
  logic [8:0]  rem_diff;
  logic [2:0]  sector_next;
  logic [5:0]  rem_next;

  // hue = 35*L mod 360, then sector/remainder by reciprocal with one correction
  always_comb begin
    x_next   = 13'(label[LAB_W-1:0]) * 13'(HUE_STEP);
    qd_next  = 4'((20'(x1) * 20'd91) >> 15);
    hue_diff = x2 - 13'(qd2) * 13'(HUE_RANGE);
    if (hue_diff >= 13'(HUE_RANGE)) begin
      hue_next = 9'(hue_diff - 13'(HUE_RANGE));
    end else begin
      hue_next = 9'(hue_diff);
    end
    s_next   = 3'((18'(hue3) * 18'd273) >> 14);
    rem_diff = hue4 - 9'(s4) * 9'(SECTOR_SPAN);
    if (rem_diff >= 9'(SECTOR_SPAN)) begin
      sector_next = s4 + 3'd1;
      rem_next    = 6'(rem_diff - 9'(SECTOR_SPAN));
    end else begin
      sector_next = s4;
      rem_next    = 6'(rem_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= '{zero: (label == '0),
                  big:  (label >= LABEL_W'(SAT_SCALE)),
                  lab:  label[LAB_W-1:0]};
      for (int i = 1; i < 5; i++) begin
        tag[i] <= tag[i-1];
      end
      x1      <= x_next;
      x2      <= x1;
      qd2     <= qd_next;
      hue3    <= hue_next;
      hue4    <= hue3;
      s4      <= s_next;
      sector5 <= sector_t'(sector_next);
      rem5    <= rem_next;
    end
  end

  assign out_valid = vld[4];
  assign item = '{zero: tag[4].zero, big: tag[4].big, lab: tag[4].lab,
                  sector: sector5, rem: rem5};

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !tag[4].big && !tag[4].zero |-> rem5 < 6'(SECTOR_SPAN))
    else $error("hue remainder out of range");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !tag[4].big && !tag[4].zero |-> sector5 <= SECT_MAGENTA)
    else $error("hue sector out of range");

endmodule

// ===== rtl/core/lbrgb_level.sv =====
module lbrgb_level (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  lbrgb_pkg::hue_item_t   item,
  output logic                   out_valid,
  output lbrgb_pkg::level_item_t level
);
  import lbrgb_pkg::*;

  localparam int LEVEL_WHOLE = 1530000;
  localparam int LEVEL_DIV   = 6000;
  localparam int Q_RECIP     = 715827;
  localparam int P_RECIP     = 5242;

  typedef struct packed {
    logic    zero;
    logic    big;
    sector_t sector;
  } tag_t;

  logic [3:0]         vld;
  tag_t               tag [4];

  logic [12:0]        a6;
  logic [12:0]        b6;
  logic [14:0]        pn6;
  logic [20:0]        nq7;
  logic [20:0]        nt7;
  logic [14:0]        pn7;
  logic [7:0]         pq7;
  logic [20:0]        nq8;
  logic [20:0]        nt8;
  logic [8:0]         qq8;
  logic [8:0]         qt8;
  logic [7:0]         p8;
  logic [7:0]         p9;
  logic [7:0]         q9;
  logic [7:0]         t9;

  logic [6:0]         sat_diff;
  logic [12:0]        a_next;
  logic [12:0]        b_next;
  logic [14:0]        pn_next;
  logic [20:0]        nq_next;
  logic [20:0]        nt_next;
  logic [7:0]         pq_next;
  logic [8:0]         qq_next;
  logic [8:0]         qt_next;
  logic [14:0]        p_rem;
  logic [7:0]         p_next;
  logic [20:0]        q_rem;
  logic [20:0]        t_rem;
  logic [8:0]         q_fix;
  logic [8:0]         t_fix;

  function automatic logic [7:0] sat_level(logic [8:0] v);
    return v[8] ? FULL_LEVEL : v[7:0];
  endfunction

  always_comb begin
    sat_diff = 7'(SAT_SCALE) - item.lab;
    a_next   = 13'(sat_diff) * 13'(item.rem);
    b_next   = 13'(sat_diff) * 13'(6'(SECTOR_SPAN) - item.rem);
    pn_next  = 15'(item.lab) * 15'(FULL_LEVEL);

    nq_next  = 21'(LEVEL_WHOLE) - 21'(a6) * 21'(FULL_LEVEL);
    nt_next  = 21'(LEVEL_WHOLE) - 21'(b6) * 21'(FULL_LEVEL);
    pq_next  = 8'((28'(pn6) * 28'(P_RECIP)) >> 19);

    qq_next  = 9'((42'(nq7) * 42'(Q_RECIP)) >> 32);
    qt_next  = 9'((42'(nt7) * 42'(Q_RECIP)) >> 32);
    p_rem    = pn7 - 15'(pq7) * 15'(SAT_SCALE);
    p_next   = (p_rem >= 15'(SAT_SCALE)) ? pq7 + 8'd1 : pq7;

    q_rem    = nq8 - 21'(qq8) * 21'(LEVEL_DIV);
    t_rem    = nt8 - 21'(qt8) * 21'(LEVEL_DIV);
    q_fix    = (q_rem >= 21'(LEVEL_DIV)) ? qq8 + 9'd1 : qq8;
    t_fix    = (t_rem >= 21'(LEVEL_DIV)) ? qt8 + 9'd1 : qt8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= '{zero: item.zero, big: item.big, sector: item.sector};
      for (int i = 1; i < 4; i++) begin
        tag[i] <= tag[i-1];
      end
      a6  <= a_next;
      b6  <= b_next;
      pn6 <= pn_next;
      nq7 <= nq_next;
      nt7 <= nt_next;
      pn7 <= pn6;
      pq7 <= pq_next;
      nq8 <= nq7;
      nt8 <= nt7;
      qq8 <= qq_next;
      qt8 <= qt_next;
      p8  <= p_next;
      p9  <= p8;
      q9  <= sat_level(q_fix);
      t9  <= sat_level(t_fix);
    end
  end

  assign out_valid = vld[3];
  assign level = '{zero: tag[3].zero, big: tag[3].big, sector: tag[3].sector,
                   p: p9, q: q9, t: t9};

  a_p_bound: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !tag[3].big && !tag[3].zero |-> p9 <= 8'd252)
    else $error("p level above bound for small label");

  a_order: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !tag[3].big && !tag[3].zero |-> q9 >= p9 && t9 >= p9)
    else $error("falling level below floor level");

endmodule

// ===== rtl/core/label_to_rgb_color.sv =====
// Label to RGB color mapper.
// label_ch carries one 16-bit segment label per transaction; color_ch
// returns one RGB pixel (red, green, blue, 8 bits each) per label, in order.
// Label 0 gives gray (128,128,128); labels of 100 and above give white;
// others follow an HSV-style wheel, hue 35*label mod 360, saturation
// falling by 1/100 per label.
// Pipeline: ten stages (five hue stages, four level stages for the
// reciprocal divides and their corrections, one output register).
// Throughput: one transaction per cycle on both channels, except while stalled.
// Stall: when color_ch is held off, the whole pipeline freezes and
// label_ch.ready drops; an empty output register lets the pipe advance.
// Reset: rst (synchronous, active high) clears every stage valid; no
// transaction is in flight afterwards.
module label_to_rgb_color (
  input logic         clk,
  input logic         rst,
  lbrgb_in_if.sink    label_ch,
  lbrgb_out_if.source color_ch
);
  import lbrgb_pkg::*;

  logic               en;
  logic               hue_valid;
  hue_item_t          hue_item;
  logic               lvl_valid;
  level_item_t        lvl_item;

  logic               color_valid;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;
  logic [LEVEL_W-1:0] red_next;
  logic [LEVEL_W-1:0] green_next;
  logic [LEVEL_W-1:0] blue_next;

  assign en = !color_valid || color_ch.ready;
  assign label_ch.ready = en;

  lbrgb_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (label_ch.valid),
    .label     (label_ch.label),
    .out_valid (hue_valid),
    .item      (hue_item)
  );

  lbrgb_level u_level (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (hue_valid),
    .item      (hue_item),
    .out_valid (lvl_valid),
    .level     (lvl_item)
  );

  always_comb begin
    case (lvl_item.sector)
      SECT_RED: begin
        red_next = FULL_LEVEL; green_next = lvl_item.t; blue_next = lvl_item.p;
      end
      SECT_YELLOW: begin
        red_next = lvl_item.q; green_next = FULL_LEVEL; blue_next = lvl_item.p;
      end
      SECT_GREEN: begin
        red_next = lvl_item.p; green_next = FULL_LEVEL; blue_next = lvl_item.t;
      end
      SECT_CYAN: begin
        red_next = lvl_item.p; green_next = lvl_item.q; blue_next = FULL_LEVEL;
      end
      SECT_BLUE: begin
        red_next = lvl_item.t; green_next = lvl_item.p; blue_next = FULL_LEVEL;
      end
      default: begin
        red_next = FULL_LEVEL; green_next = lvl_item.p; blue_next = lvl_item.q;
      end
    endcase
    if (lvl_item.zero) begin
      red_next = GRAY_LEVEL; green_next = GRAY_LEVEL; blue_next = GRAY_LEVEL;
    end else if (lvl_item.big) begin
      red_next = FULL_LEVEL; green_next = FULL_LEVEL; blue_next = FULL_LEVEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (en) begin
      color_valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign color_ch.valid = color_valid;
  assign color_ch.red   = red;
  assign color_ch.green = green;
  assign color_ch.blue  = blue;

  a_color_shape: assert property (@(posedge clk) disable iff (rst)
    color_valid |-> red == FULL_LEVEL || green == FULL_LEVEL || blue == FULL_LEVEL ||
                    (red == GRAY_LEVEL && green == GRAY_LEVEL && blue == GRAY_LEVEL))
    else $error("pixel has no full channel and is not gray");

endmodule
